// File: design/lbf_pkg.sv
// ---------------------------------------------------------------------------
// lbf_pkg: shared types and constants of the line box filter
// Widths, the chain depth and the reciprocal table used for the window mean.
// ---------------------------------------------------------------------------
package lbf_pkg;

    localparam int MAX_RADIUS  = 63;
    localparam int SAMPLE_BITS = 16;
    localparam int R_W         = 6;
    localparam int W_W         = R_W + 1;
    localparam int SUM_W       = 23;
    localparam int POS_W       = 13;
    localparam int CHAIN_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int IDX_W       = $clog2(CHAIN_DEPTH);
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RONE        = 2 ** RECIP_SHIFT;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // APB register addresses
    localparam logic [1:0] ADDR_RADIUS = 2'd0;

    // ceil(2^30 / (2r+1)) for r = 0 .. 63; exact truncated quotient for sums < 2^23
    localparam logic [RECIP_W-1:0] RECIP [64] = '{
        31'((RONE + 0) / 1),     31'((RONE + 2) / 3),     31'((RONE + 4) / 5),
        31'((RONE + 6) / 7),     31'((RONE + 8) / 9),     31'((RONE + 10) / 11),
        31'((RONE + 12) / 13),   31'((RONE + 14) / 15),   31'((RONE + 16) / 17),
        31'((RONE + 18) / 19),   31'((RONE + 20) / 21),   31'((RONE + 22) / 23),
        31'((RONE + 24) / 25),   31'((RONE + 26) / 27),   31'((RONE + 28) / 29),
        31'((RONE + 30) / 31),   31'((RONE + 32) / 33),   31'((RONE + 34) / 35),
        31'((RONE + 36) / 37),   31'((RONE + 38) / 39),   31'((RONE + 40) / 41),
        31'((RONE + 42) / 43),   31'((RONE + 44) / 45),   31'((RONE + 46) / 47),
        31'((RONE + 48) / 49),   31'((RONE + 50) / 51),   31'((RONE + 52) / 53),
        31'((RONE + 54) / 55),   31'((RONE + 56) / 57),   31'((RONE + 58) / 59),
        31'((RONE + 60) / 61),   31'((RONE + 62) / 63),   31'((RONE + 64) / 65),
        31'((RONE + 66) / 67),   31'((RONE + 68) / 69),   31'((RONE + 70) / 71),
        31'((RONE + 72) / 73),   31'((RONE + 74) / 75),   31'((RONE + 76) / 77),
        31'((RONE + 78) / 79),   31'((RONE + 80) / 81),   31'((RONE + 82) / 83),
        31'((RONE + 84) / 85),   31'((RONE + 86) / 87),   31'((RONE + 88) / 89),
        31'((RONE + 90) / 91),   31'((RONE + 92) / 93),   31'((RONE + 94) / 95),
        31'((RONE + 96) / 97),   31'((RONE + 98) / 99),   31'((RONE + 100) / 101),
        31'((RONE + 102) / 103), 31'((RONE + 104) / 105), 31'((RONE + 106) / 107),
        31'((RONE + 108) / 109), 31'((RONE + 110) / 111), 31'((RONE + 112) / 113),
        31'((RONE + 114) / 115), 31'((RONE + 116) / 117), 31'((RONE + 118) / 119),
        31'((RONE + 120) / 121), 31'((RONE + 122) / 123), 31'((RONE + 124) / 125),
        31'((RONE + 126) / 127)
    };

    // window sum handed to the divider
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [R_W-1:0]   radius;
        logic             last;
    } lbf_sum_t;

endpackage

// File: design/lbf_if.sv
// ---------------------------------------------------------------------------
// lbf_in_if / lbf_out_if: valid/ready channels of the line box filter
// Input samples and filtered results.
// ---------------------------------------------------------------------------
interface lbf_in_if;
    logic                           valid;
    logic                           ready;
    logic [lbf_pkg::SAMPLE_BITS-1:0] sample;
    logic                           last_in_line;

    modport source (output valid, output sample, output last_in_line, input ready);
    modport sink   (input valid, input sample, input last_in_line, output ready);
endinterface

interface lbf_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbf_pkg::SAMPLE_BITS-1:0] mean_value;
    logic                           last_of_line;

    modport source (output valid, output mean_value, output last_of_line, input ready);
    modport sink   (input valid, input mean_value, input last_of_line, output ready);
endinterface

// File: design/lbf_cell.sv
// ---------------------------------------------------------------------------
// lbf_cell: one sample cell of the delay chain
// Takes its upper neighbor on a shift, or the new sample when selected.
// ---------------------------------------------------------------------------
module lbf_cell (
    input  logic                            clk,
    input  logic                            shift,
    input  logic                            load,
    input  logic [lbf_pkg::SAMPLE_BITS-1:0] din_new,
    input  logic [lbf_pkg::SAMPLE_BITS-1:0] din_next,
    output logic [lbf_pkg::SAMPLE_BITS-1:0] q
);

    logic [lbf_pkg::SAMPLE_BITS-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= load ? din_new : din_next;
        end
    end

    assign q = q_reg;

endmodule

// File: design/lbf_chain.sv
// ---------------------------------------------------------------------------
// lbf_chain: variable length sample delay line
// New samples enter at cell 2r; cell 0 then shows the sample one window back.
// ---------------------------------------------------------------------------
module lbf_chain (
    input  logic                            clk,
    input  logic                            shift,
    input  logic                            load,
    input  logic [lbf_pkg::IDX_W-1:0]       ins_idx,
    input  logic [lbf_pkg::SAMPLE_BITS-1:0] din,
    output logic [lbf_pkg::SAMPLE_BITS-1:0] tail
);

    logic [lbf_pkg::SAMPLE_BITS-1:0] q [lbf_pkg::CHAIN_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < lbf_pkg::CHAIN_DEPTH; gi++)
        begin : g_cell
            logic [lbf_pkg::SAMPLE_BITS-1:0] nxt;
            logic                            sel;

            // top cell just recirculates
            if (gi == lbf_pkg::CHAIN_DEPTH - 1)
            begin : g_top
                assign nxt = q[gi];
            end
            else
            begin : g_mid
                assign nxt = q[gi+1];
            end

            assign sel = load && (ins_idx == lbf_pkg::IDX_W'(gi));

            lbf_cell u_cell (
                .clk      (clk),
                .shift    (shift),
                .load     (sel),
                .din_new  (din),
                .din_next (nxt),
                .q        (q[gi])
            );
        end
    endgenerate

    assign tail = q[0];

endmodule

// File: design/lbf_divider.sv
// ---------------------------------------------------------------------------
// lbf_divider: window sum to mean
// Multiply by a reciprocal, then shift and saturate into the output register.
// ---------------------------------------------------------------------------
module lbf_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  lbf_pkg::lbf_sum_t req,
    lbf_out_if.source         out_ch
);

    logic                          p_v_reg;
    logic [lbf_pkg::PROD_W-1:0]    p_prod_reg;
    logic                          p_last_reg;
    logic                          o_v_reg;
    logic [lbf_pkg::SAMPLE_BITS-1:0] o_mean_reg;
    logic                          o_last_reg;
    logic                          o_en;
    logic                          p_en;
    logic [lbf_pkg::PROD_W-lbf_pkg::RECIP_SHIFT-1:0] quot;
    logic [lbf_pkg::SAMPLE_BITS-1:0] mean_next;

    assign o_en      = !o_v_reg || out_ch.ready;
    assign p_en      = !p_v_reg || o_en;
    assign req_ready = p_en;

    // quotient and saturation
    assign quot = p_prod_reg[lbf_pkg::PROD_W-1:lbf_pkg::RECIP_SHIFT];
    assign mean_next = (quot > {{(lbf_pkg::PROD_W-lbf_pkg::RECIP_SHIFT-lbf_pkg::SAMPLE_BITS){1'b0}},
                                {lbf_pkg::SAMPLE_BITS{1'b1}}})
                     ? {lbf_pkg::SAMPLE_BITS{1'b1}}
                     : quot[lbf_pkg::SAMPLE_BITS-1:0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (p_en)
            begin
                p_v_reg <= req_valid;
            end
            if (o_en)
            begin
                o_v_reg <= p_v_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (p_en)
        begin
            p_prod_reg <= lbf_pkg::PROD_W'(req.sum * lbf_pkg::RECIP[req.radius]);
            p_last_reg <= req.last;
        end
        if (o_en)
        begin
            o_mean_reg <= mean_next;
            o_last_reg <= p_last_reg;
        end
    end

    assign out_ch.valid        = o_v_reg;
    assign out_ch.mean_value   = o_mean_reg;
    assign out_ch.last_of_line = o_last_reg;

endmodule

// File: design/line_box_filter_clamped_edges.sv
// ---------------------------------------------------------------------------
// line_box_filter_clamped_edges: 1-D box filter with clamped line edges
// Running window sum over a chain of sample cells, reciprocal divider.
// ---------------------------------------------------------------------------
// One sample is taken per clock while the result path flows; each result
// passes three registers on its way out (sum register, multiplier
// register, output register). The last sample of a line with nonzero radius
// r starts a flush of r steps, at most one trailing result per step, in which
// no sample is taken; the flush walks the cell chain one step a cycle while
// the result path flows. The radius register is sampled at each line start.
module line_box_filter_clamped_edges (
    input  logic        clk,
    input  logic        rst_n,
    lbf_in_if.sink      in_ch,
    lbf_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lbf_pkg::R_W-1:0]         radius_reg;
    logic [lbf_pkg::R_W-1:0]         line_r_reg;
    logic [lbf_pkg::SAMPLE_BITS-1:0] first_reg;
    logic [lbf_pkg::SUM_W-1:0]       sum_reg;
    logic [lbf_pkg::POS_W-1:0]       pos_reg;
    logic                            flush_reg;
    logic [lbf_pkg::R_W-1:0]         m_reg;
    logic signed [lbf_pkg::POS_W:0]  fpos_reg;
    logic [lbf_pkg::POS_W:0]         kpm_reg;
    logic [lbf_pkg::SAMPLE_BITS-1:0] slast_reg;
    logic                            s1_v_reg;
    lbf_pkg::lbf_sum_t               s1_reg;

    logic                            div_ready;
    logic                            s1_en;
    logic                            accept;
    logic                            step;
    logic                            first;
    logic [lbf_pkg::R_W-1:0]         r_cur;
    logic [lbf_pkg::W_W-1:0]         w_cur;
    logic [lbf_pkg::SAMPLE_BITS-1:0] fs;
    logic [lbf_pkg::SAMPLE_BITS-1:0] tail;
    logic [lbf_pkg::SAMPLE_BITS-1:0] old_acc;
    logic [lbf_pkg::SAMPLE_BITS-1:0] old_f;
    logic [lbf_pkg::SUM_W-1:0]       sum_acc;
    logic [lbf_pkg::SUM_W-1:0]       sum_f;
    logic                            emit_acc;
    logic                            emit_f;
    logic                            cfg_wr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == lbf_pkg::ADDR_RADIUS);
    assign prdata = {{(32-lbf_pkg::R_W){1'b0}}, radius_reg};

    // handshakes
    assign s1_en       = !s1_v_reg || div_ready;
    assign in_ch.ready = s1_en && !flush_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign step        = s1_en && flush_reg;

    // request path
    assign first = (pos_reg == '0);
    assign r_cur = first ? radius_reg : line_r_reg;
    assign w_cur = {r_cur, 1'b1};
    assign fs    = first ? in_ch.sample : first_reg;
    assign old_acc = (pos_reg <= lbf_pkg::POS_W'(w_cur)) ? fs : tail;
    assign sum_acc = first
                   ? lbf_pkg::SUM_W'(w_cur * in_ch.sample)
                   : sum_reg + lbf_pkg::SUM_W'(in_ch.sample) - lbf_pkg::SUM_W'(old_acc);
    assign emit_acc = (pos_reg >= lbf_pkg::POS_W'(r_cur));

    // flush path, left clamp while the window reaches before the line start
    assign old_f  = (fpos_reg[lbf_pkg::POS_W] || fpos_reg == '0) ? first_reg : tail;
    assign sum_f  = sum_reg + lbf_pkg::SUM_W'(slast_reg) - lbf_pkg::SUM_W'(old_f);
    assign emit_f = (kpm_reg >= (lbf_pkg::POS_W+1)'(line_r_reg));

    lbf_chain u_chain (
        .clk     (clk),
        .shift   (accept || step),
        .load    (accept),
        .ins_idx ({r_cur, 1'b0}),
        .din     (in_ch.sample),
        .tail    (tail)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            line_r_reg <= '0;
            first_reg  <= '0;
            sum_reg    <= '0;
            pos_reg    <= '0;
            flush_reg  <= 1'b0;
            m_reg      <= '0;
            fpos_reg   <= '0;
            kpm_reg    <= '0;
            s1_v_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                radius_reg <= pwdata[lbf_pkg::R_W-1:0];
            end
            if (accept)
            begin
                if (first)
                begin
                    line_r_reg <= radius_reg;
                    first_reg  <= in_ch.sample;
                end
                sum_reg <= sum_acc;
                if (in_ch.last_in_line)
                begin
                    pos_reg <= '0;
                    if (r_cur != '0)
                    begin
                        flush_reg <= 1'b1;
                        m_reg     <= lbf_pkg::R_W'(1);
                        fpos_reg  <= $signed({1'b0, pos_reg})
                                   - $signed((lbf_pkg::POS_W+1)'({r_cur, 1'b0}));
                        kpm_reg   <= (lbf_pkg::POS_W+1)'(pos_reg) + 1'b1;
                    end
                end
                else if (pos_reg != lbf_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else if (step)
            begin
                sum_reg <= sum_f;
                if (m_reg == line_r_reg)
                begin
                    flush_reg <= 1'b0;
                end
                else
                begin
                    m_reg    <= m_reg + 1'b1;
                    fpos_reg <= fpos_reg + (lbf_pkg::POS_W+1)'(1);
                    kpm_reg  <= kpm_reg + 1'b1;
                end
            end
            if (s1_en)
            begin
                s1_v_reg <= (accept && emit_acc) || (step && emit_f);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slast_reg <= in_ch.sample;
        end
        if (s1_en)
        begin
            if (flush_reg)
            begin
                s1_reg.sum    <= sum_f;
                s1_reg.radius <= line_r_reg;
                s1_reg.last   <= (m_reg == line_r_reg);
            end
            else
            begin
                s1_reg.sum    <= sum_acc;
                s1_reg.radius <= r_cur;
                s1_reg.last   <= in_ch.last_in_line && (r_cur == '0);
            end
        end
    end

    lbf_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_v_reg),
        .req_ready (div_ready),
        .req       (s1_reg),
        .out_ch    (out_ch)
    );

endmodule

// File: design/lbf_checker.sv
// ---------------------------------------------------------------------------
// lbf_checker: port level checks of the line box filter
// Result hold under stall and register port behavior.
// ---------------------------------------------------------------------------
module lbf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] mean_value,
    input  logic        last_of_line,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata
);

    // a stalled result stays and keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(last_of_line))
        else $error("result dropped or changed under stall");

    // radius write reads back
    a_cfg_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == lbf_pkg::ADDR_RADIUS
        |=> prdata == {26'd0, $past(pwdata[5:0])})
        else $error("radius readback mismatch");

    // readback only changes on a radius write
    a_cfg_keep: assert property (@(posedge clk) disable iff (!rst_n)
        !(psel && penable && pwrite && paddr == lbf_pkg::ADDR_RADIUS) |=> $stable(prdata))
        else $error("radius changed without write");

endmodule

bind line_box_filter_clamped_edges lbf_checker u_lbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .mean_value   (out_ch.mean_value),
    .last_of_line (out_ch.last_of_line),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

// File: tb/line_box_filter_clamped_edges_tb.sv
// ---------------------------------------------------------------------------
// line_box_filter_clamped_edges_tb: self-checking bench of the line box filter
// Lines of samples go in over the request channel under random idling on both
// sides; a predictor works out each windowed mean with clamped edges and the
// results are checked in order, field by field.
// ---------------------------------------------------------------------------
module line_box_filter_clamped_edges_tb;

    typedef struct packed {
        logic [lbf_pkg::SAMPLE_BITS-1:0] mean_value;
        logic                            last_of_line;
    } mean_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lbf_in_if  in_ch ();
    lbf_out_if out_ch ();

    line_box_filter_clamped_edges uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [15:0]               line_hist [128];
    logic [6:0]                hist_wr;
    logic [15:0]               first_val;
    logic [lbf_pkg::SUM_W-1:0] win_sum;
    logic [lbf_pkg::POS_W-1:0] line_pos;
    logic [lbf_pkg::R_W-1:0]   line_rad;
    logic [lbf_pkg::R_W-1:0]   rad_reg;

    mean_t expected_means [$];
    int    mismatches;
    int    means_seen;
    int    lines_sent;
    bit    no_idle;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // sample at distance d back from position k, clamped to the first sample
    function automatic logic [15:0] older_val(int k, int d, logic [6:0] cur);
        if (k <= d)
            return first_val;
        return line_hist[7'(cur - d)];
    endfunction

    function automatic mean_t make_mean(logic [lbf_pkg::SUM_W-1:0] s, int w, bit lst);
        mean_t m;
        int unsigned q;
        q = s / w;
        if (q > 65535)
            q = 65535;
        m.mean_value   = q[15:0];
        m.last_of_line = lst;
        return m;
    endfunction

    // advance the filter model by one accepted sample
    task automatic predict_window(logic [15:0] s, bit lst);
        int k;
        int r;
        int w;
        logic [6:0] cur;
        logic [lbf_pkg::SUM_W-1:0] t;
        k = line_pos;
        if (k == 0)
        begin
            line_rad  = rad_reg;
            first_val = s;
        end
        cur = hist_wr;
        line_hist[cur] = s;
        hist_wr = hist_wr + 7'd1;
        r = line_rad;
        w = 2 * r + 1;
        if (k == 0)
            win_sum = lbf_pkg::SUM_W'(w * s);
        else
            win_sum = lbf_pkg::SUM_W'(win_sum + s - older_val(k, w, cur));
        if (k >= r)
            expected_means.push_back(make_mean(win_sum, w, lst && r == 0));
        if (lst)
        begin
            t = win_sum;
            for (int m = 1; m <= r; m++)
            begin
                t = lbf_pkg::SUM_W'(t + s - older_val(k, w - m, cur));
                if (k + m >= r)
                    expected_means.push_back(make_mean(t, w, m == r));
            end
            line_pos = '0;
            win_sum  = '0;
        end
        else if (line_pos != lbf_pkg::POS_MAX)
            line_pos = line_pos + 1'b1;
    endtask

    // sender idle roll
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 29);
    endfunction

    // send one sample request; valid stays up until the next idle or drain
    task automatic send_sample(logic [15:0] s, bit lst);
        while (idle_now())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= s;
        in_ch.last_in_line <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_window(s, lst);
        if (lst)
            lines_sent++;
    endtask

    task automatic send_line(int len, int mode);
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: v = 16'($urandom);
                1: v = 16'hFFFF;
                2: v = (i % 2) ? 16'hFFFF : 16'h0000;
                default: v = 16'($urandom_range(0, 255)) + 16'd1000;
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    // wait for the block to drain, then let the flush tail settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_radius(logic [5:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lbf_pkg::ADDR_RADIUS;
        pwdata  <= {26'd0, r};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rad_reg = r;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // pass-through and basic edge values at radius 0
    task automatic test_passthrough();
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'h1234, 1'b1);
        wait_idle();
    endtask

    // short lines against wide windows, including one-sample lines
    task automatic test_short_lines();
        write_radius(6'd3);
        send_line(1, 0);
        send_line(2, 2);
        send_line(7, 1);
        wait_idle();
        write_radius(6'd63);
        send_line(3, 0);
        wait_idle();
    endtask

    // radius written while a line is open takes effect on the next line
    task automatic test_midline_radius();
        write_radius(6'd2);
        send_sample(16'd100, 1'b0);
        send_sample(16'd200, 1'b0);
        wait_idle();
        write_radius(6'd5);
        send_sample(16'd300, 1'b0);
        send_sample(16'd400, 1'b1);
        send_line(12, 3);
        wait_idle();
    endtask

    // random lines, mostly small radii, a few at the extremes
    task automatic test_random_lines();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < 400)
        begin
            case ($urandom_range(9))
                0: r = 63;
                1: r = 0;
                default: r = $urandom_range(1, 8);
            endcase
            write_radius(6'(r));
            no_idle = (sent >= 150 && sent < 230);
            for (int j = 0; j < 3; j++)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(100, 140)
                                              : $urandom_range(1, 30);
                send_line(len, ($urandom_range(5) == 0) ? 2 : 0);
                sent += len;
            end
            wait_idle();
        end
        no_idle = 1'b0;
    endtask

    // result checker with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                means_seen++;
                if (expected_means.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result mean=%h last=%b",
                                 out_ch.mean_value, out_ch.last_of_line);
                end
                else
                begin
                    if (out_ch.mean_value !== expected_means[0].mean_value ||
                        out_ch.last_of_line !== expected_means[0].last_of_line)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected mean=%h last=%b got mean=%h last=%b",
                                     expected_means[0].mean_value,
                                     expected_means[0].last_of_line,
                                     out_ch.mean_value, out_ch.last_of_line);
                    end
                    void'(expected_means.pop_front());
                end
            end
            out_ch.ready <= no_idle || ($urandom_range(99) >= 29);
        end
    end

    // sequence of tests
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample       = '0;
        in_ch.last_in_line = 1'b0;
        out_ch.ready       = 1'b0;
        mismatches         = 0;
        means_seen         = 0;
        lines_sent         = 0;
        no_idle            = 1'b0;
        hist_wr            = '0;
        first_val          = '0;
        win_sum            = '0;
        line_pos           = '0;
        line_rad           = '0;
        rad_reg            = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_passthrough();
        test_short_lines();
        test_midline_radius();
        test_random_lines();
        wait_idle();
        $display("covered %0d lines and %0d filtered results, radius 0 to 63",
                 lines_sent, means_seen);
        if (mismatches == 0 && expected_means.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: line_box_filter_clamped_edges.f
design/lbf_pkg.sv
design/lbf_if.sv
design/lbf_cell.sv
design/lbf_chain.sv
design/lbf_divider.sv
design/line_box_filter_clamped_edges.sv
design/lbf_checker.sv
tb/line_box_filter_clamped_edges_tb.sv
